/* src/rational_arith_reduce_top_assert.svh */
// Assertion macros for the rational arithmetic block
`ifndef RATIONAL_ARITH_REDUCE_TOP_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_TOP_ASSERT_SVH

// Same-cycle implication, reset-qualified
`define RAR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified
`define RAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rar_pkg.sv */
// Shared types and constants for the rational arithmetic block
`timescale 1ns / 1ps

package rar_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MUL_CROSS_A,
    MUL_CROSS_B,
    MUL_DEN
  } mul_step_e;

  typedef enum logic [1:0] {
    DSEL_GCD,
    DSEL_NUM,
    DSEL_DEN
  } div_sel_e;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_step_e mul_step;
    logic      sum_en;
    logic      gcd_init;
    logic      g_load;
    logic      div_start;
    div_sel_e  div_sel;
    logic      gcd_step;
    logic      qnum_en;
    logic      qden_en;
    logic      out_load;
  } rar_ctrl_t;

  typedef struct packed {
    logic trivial_gcd;
    logic lo_zero;
    logic div_done;
  } rar_stat_t;

  localparam int CMD_W       = 2;
  localparam int NUM_OUT_W   = 32;
  localparam int DEN_OUT_W   = 31;
  localparam int OUT_TDATA_W = 128;

endpackage

/* src/rar_div.sv */
// Restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rar_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  acc_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial, diff;

  assign trial = {acc_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        acc_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        acc_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = acc_q;

endmodule

/* src/rar_dp.sv */
// Datapath: sign/magnitude products, sum, Euclid GCD and reduction
`timescale 1ns / 1ps

module rar_dp #(
  parameter int VW = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rar_pkg::rar_ctrl_t             ctrl_i,
  output rar_pkg::rar_stat_t             stat_o,
  input  rar_pkg::op_e                   op_i,
  input  logic [VW-1:0]                  ln_i,
  input  logic [VW-1:0]                  ld_i,
  input  logic [VW-1:0]                  rn_i,
  input  logic [VW-1:0]                  rd_i,
  output logic [rar_pkg::OUT_TDATA_W-1:0] tdata_o,
  output logic                           zden_o
);

  localparam int MW = 2 * VW;

  rar_pkg::op_e  op_q;
  logic [VW-1:0] ln_m_q, ld_m_q, rn_m_q, rd_m_q;
  logic          ln_s_q, ld_s_q, rn_s_q, rd_s_q;

  logic [VW-1:0] mul_a, mul_b;
  logic          mul_sa, mul_sb;
  logic [MW-1:0] prod;

  logic [MW-1:0] p0_q, p1_q, den_q, num_q;
  logic          s0_q, s1_q, dsgn_q, nsgn_q;
  logic [MW-1:0] num_d;
  logic          nsgn_d;
  logic [MW-1:0] diff01, diff10;

  logic [MW-1:0] hi_q, lo_q, g_q, rnum_q, rden_q;
  logic [MW-1:0] div_dividend, div_divisor, div_quot, div_rem;
  logic          div_done;

  logic [MW+31:0] num_ext, den_ext, rnum_ext, rden_ext;
  logic           zden, neg;

  // operand capture, two's complement to sign/magnitude
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q   <= op_i;
      ln_s_q <= ln_i[VW-1];
      ld_s_q <= ld_i[VW-1];
      rn_s_q <= rn_i[VW-1];
      rd_s_q <= rd_i[VW-1];
      ln_m_q <= ln_i[VW-1] ? (~ln_i + VW'(1)) : ln_i;
      ld_m_q <= ld_i[VW-1] ? (~ld_i + VW'(1)) : ld_i;
      rn_m_q <= rn_i[VW-1] ? (~rn_i + VW'(1)) : rn_i;
      rd_m_q <= rd_i[VW-1] ? (~rd_i + VW'(1)) : rd_i;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = ln_m_q;
    mul_sa = ln_s_q;
    mul_b  = rd_m_q;
    mul_sb = rd_s_q;
    case (ctrl_i.mul_step)
      rar_pkg::MUL_CROSS_A: begin
        if (op_q == rar_pkg::OP_MUL) begin
          mul_b  = rn_m_q;
          mul_sb = rn_s_q;
        end
      end
      rar_pkg::MUL_CROSS_B: begin
        mul_a  = rn_m_q;
        mul_sa = rn_s_q;
        mul_b  = ld_m_q;
        mul_sb = ld_s_q;
      end
      rar_pkg::MUL_DEN: begin
        mul_a  = ld_m_q;
        mul_sa = ld_s_q;
        if (op_q == rar_pkg::OP_DIV) begin
          mul_b  = rn_m_q;
          mul_sb = rn_s_q;
        end
      end
      default: ;
    endcase
  end

  assign prod = {{VW{1'b0}}, mul_a} * {{VW{1'b0}}, mul_b};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      case (ctrl_i.mul_step)
        rar_pkg::MUL_CROSS_A: begin
          p0_q <= prod;
          s0_q <= mul_sa ^ mul_sb;
        end
        rar_pkg::MUL_CROSS_B: begin
          p1_q <= prod;
          s1_q <= mul_sa ^ mul_sb ^ (op_q == rar_pkg::OP_SUB);
        end
        default: begin
          den_q  <= prod;
          dsgn_q <= mul_sa ^ mul_sb;
        end
      endcase
    end
  end

  // signed-magnitude sum of the cross products for add and subtract; multiply and divide pass the first product
  assign diff01 = p0_q - p1_q;
  assign diff10 = p1_q - p0_q;

  always_comb begin
    num_d  = p0_q;
    nsgn_d = s0_q;
    if (op_q == rar_pkg::OP_ADD || op_q == rar_pkg::OP_SUB) begin
      if (s0_q == s1_q) begin
        num_d = p0_q + p1_q;
      end else if (p0_q >= p1_q) begin
        num_d = diff01;
      end else begin
        num_d  = diff10;
        nsgn_d = s1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      num_q  <= num_d;
      nsgn_q <= nsgn_d;
    end
  end

  // Euclid state and reduced magnitudes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.gcd_init) begin
      hi_q <= num_q;
      lo_q <= den_q;
    end else if (ctrl_i.gcd_step) begin
      hi_q <= lo_q;
      lo_q <= div_rem;
    end
    if (ctrl_i.g_load) begin
      g_q <= stat_o.trivial_gcd ? MW'(1) : hi_q;
    end
    if (ctrl_i.qnum_en) begin
      rnum_q <= div_quot;
    end
    if (ctrl_i.qden_en) begin
      rden_q <= div_quot;
    end
  end

  always_comb begin
    div_dividend = hi_q;
    div_divisor  = lo_q;
    case (ctrl_i.div_sel)
      rar_pkg::DSEL_NUM: begin
        div_dividend = num_q;
        div_divisor  = g_q;
      end
      rar_pkg::DSEL_DEN: begin
        div_dividend = den_q;
        div_divisor  = g_q;
      end
      default: ;
    endcase
  end

  rar_div #(
    .W (MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign stat_o.trivial_gcd = (num_q == '0) || (den_q == '0);
  assign stat_o.lo_zero     = (lo_q == '0);
  assign stat_o.div_done    = div_done;

  // output beat
  assign num_ext  = {32'b0, num_q};
  assign den_ext  = {32'b0, den_q};
  assign rnum_ext = {32'b0, rnum_q};
  assign rden_ext = {32'b0, rden_q};
  assign zden     = (den_q == '0);
  assign neg      = !zden && (num_q != '0) && (nsgn_q != dsgn_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      tdata_o <= {1'b0,
                  rden_ext[rar_pkg::DEN_OUT_W-1:0],
                  rnum_ext[rar_pkg::NUM_OUT_W-1:0],
                  den_ext[rar_pkg::DEN_OUT_W-1:0],
                  num_ext[rar_pkg::NUM_OUT_W-1:0],
                  neg};
      zden_o  <= zden;
    end
  end

endmodule

/* src/rar_ctrl.sv */
// Controller: sequences products, sum, GCD loop and reduction
`timescale 1ns / 1ps

module rar_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  input  rar_pkg::rar_stat_t stat_i,
  output rar_pkg::rar_ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_DEN,
    S_SUM,
    S_GCD_INIT,
    S_GCD_START,
    S_GCD_WAIT,
    S_DIVN_START,
    S_DIVN_WAIT,
    S_DIVD_START,
    S_DIVD_WAIT,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q;
  logic   out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.load = s_valid_i;
        if (s_valid_i) begin
          state_d = S_MUL_A;
        end
      end
      S_MUL_A: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_step = rar_pkg::MUL_CROSS_A;
        state_d         = S_MUL_B;
      end
      S_MUL_B: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_step = rar_pkg::MUL_CROSS_B;
        state_d         = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_step = rar_pkg::MUL_DEN;
        state_d         = S_SUM;
      end
      S_SUM: begin
        ctrl_o.sum_en = 1'b1;
        state_d       = S_GCD_INIT;
      end
      S_GCD_INIT: begin
        if (stat_i.trivial_gcd) begin
          ctrl_o.g_load = 1'b1;
          state_d       = S_DIVN_START;
        end else begin
          ctrl_o.gcd_init = 1'b1;
          state_d         = S_GCD_START;
        end
      end
      S_GCD_START: begin
        if (stat_i.lo_zero) begin
          ctrl_o.g_load = 1'b1;
          state_d       = S_DIVN_START;
        end else begin
          ctrl_o.div_start = 1'b1;
          ctrl_o.div_sel   = rar_pkg::DSEL_GCD;
          state_d          = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (stat_i.div_done) begin
          ctrl_o.gcd_step = 1'b1;
          state_d         = S_GCD_START;
        end
      end
      S_DIVN_START: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = rar_pkg::DSEL_NUM;
        state_d          = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (stat_i.div_done) begin
          ctrl_o.qnum_en = 1'b1;
          state_d        = S_DIVD_START;
        end
      end
      S_DIVD_START: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = rar_pkg::DSEL_DEN;
        state_d          = S_DIVD_WAIT;
      end
      S_DIVD_WAIT: begin
        if (stat_i.div_done) begin
          ctrl_o.qden_en = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* src/rational_arith_reduce_top.sv */
// Top level of the rational arithmetic block with GCD reduction
// One item at a time: an input beat is taken only while the controller is idle, and the
// finished result sits in an output register so the next item can start while it waits.
// The single shared serial divider gives one quotient bit per cycle on 2*VALUE_WIDTH-bit
// magnitudes, for every Euclid remainder step of the GCD and for both reductions; when either
// magnitude is zero there are no remainder steps.
`timescale 1ns / 1ps

module rational_arith_reduce_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // left_numerator, left_denominator, right_numerator, right_denominator, zero pad
  input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // command
  input  logic [rar_pkg::CMD_W-1:0]            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // negative, raw_numerator_mag, raw_denominator_mag, reduced_numerator_mag,
  // reduced_denominator_mag, zero pad
  output logic [rar_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // zero_denominator
  output logic [0:0]                           m_axis_tuser
);

  localparam int VW = VALUE_WIDTH;

  rar_pkg::rar_ctrl_t ctrl;
  rar_pkg::rar_stat_t stat;
  logic               zden;

  rar_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  rar_dp #(
    .VW (VW)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .op_i    (rar_pkg::op_e'(s_axis_tuser)),
    .ln_i    (s_axis_tdata[VW-1:0]),
    .ld_i    (s_axis_tdata[2*VW-1:VW]),
    .rn_i    (s_axis_tdata[3*VW-1:2*VW]),
    .rd_i    (s_axis_tdata[4*VW-1:3*VW]),
    .tdata_o (m_axis_tdata),
    .zden_o  (zden)
  );

  assign m_axis_tuser = zden;

  `include "rational_arith_reduce_top_assert.svh"

  `RAR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `RAR_ASSERT_SAME(a_zden_not_negative, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[0], "negative with zero denominator")
  `RAR_ASSERT_SAME(a_zden_unreduced, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[95:64] == m_axis_tdata[32:1]) && (m_axis_tdata[126:96] == m_axis_tdata[63:33]), "reduced differs from raw with zero denominator")

endmodule

/* dv/rational_arith_reduce_checker.sv */
// Scoreboard for the rational arithmetic block: predicts each result beat and checks it
`timescale 1ns / 1ps

module rational_arith_reduce_checker
  import rar_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0] in_data_i,
  input  logic [CMD_W-1:0]                   in_user_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [OUT_TDATA_W-1:0]             out_data_i,
  input  logic [0:0]                         out_user_i,
  output int                                 errors_o,
  output int                                 pending_o,
  output int                                 results_o,
  output int                                 zero_den_seen_o
);

  typedef struct {
    bit              neg;
    longint unsigned mag;
  } sign_mag_t;

  // Same layout as {tuser, tdata[126:0]}
  typedef struct packed {
    logic                 zero_den;
    logic [DEN_OUT_W-1:0] red_den;
    logic [NUM_OUT_W-1:0] red_num;
    logic [DEN_OUT_W-1:0] raw_den;
    logic [NUM_OUT_W-1:0] raw_num;
    logic                 negative;
  } fraction_t;

  fraction_t expected_q[$];

  function automatic sign_mag_t split_sign(input logic [VALUE_WIDTH-1:0] v);
    sign_mag_t              r;
    logic [VALUE_WIDTH-1:0] m;
    m     = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    r.neg = v[VALUE_WIDTH-1];
    r.mag = 64'(m);
    return r;
  endfunction

  function automatic sign_mag_t mag_mul(input sign_mag_t a, input sign_mag_t b);
    sign_mag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic sign_mag_t mag_add(input sign_mag_t a, input sign_mag_t b);
    sign_mag_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic fraction_t predict_fraction(input op_e op,
                                                 input logic [4*VALUE_WIDTH-1:0] operands);
    sign_mag_t       ln, ld, rn, rd, num, den, t;
    longint unsigned hi, lo, rem, g;
    fraction_t       r;
    ln = split_sign(operands[0*VALUE_WIDTH +: VALUE_WIDTH]);
    ld = split_sign(operands[1*VALUE_WIDTH +: VALUE_WIDTH]);
    rn = split_sign(operands[2*VALUE_WIDTH +: VALUE_WIDTH]);
    rd = split_sign(operands[3*VALUE_WIDTH +: VALUE_WIDTH]);
    case (op)
      OP_ADD: begin
        num = mag_add(mag_mul(ln, rd), mag_mul(rn, ld));
        den = mag_mul(ld, rd);
      end
      OP_SUB: begin
        t = mag_mul(rn, ld);
        if (t.mag != 0) t.neg = !t.neg;
        num = mag_add(mag_mul(ln, rd), t);
        den = mag_mul(ld, rd);
      end
      OP_MUL: begin
        num = mag_mul(ln, rn);
        den = mag_mul(ld, rd);
      end
      default: begin
        num = mag_mul(ln, rd);
        den = mag_mul(ld, rn);
      end
    endcase
    hi = (num.mag > den.mag) ? num.mag : den.mag;
    lo = (num.mag > den.mag) ? den.mag : num.mag;
    if (hi == 0 || lo == 0) begin
      g = 1;
    end else begin
      while (lo != 0) begin
        rem = hi % lo;
        hi  = lo;
        lo  = rem;
      end
      g = hi;
    end
    r.zero_den = (den.mag == 0);
    r.negative = !r.zero_den && (num.mag != 0) && (num.neg != den.neg);
    r.raw_num  = num.mag[NUM_OUT_W-1:0];
    r.raw_den  = den.mag[DEN_OUT_W-1:0];
    r.red_num  = NUM_OUT_W'(num.mag / g);
    r.red_den  = DEN_OUT_W'(den.mag / g);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors_o++;
    $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
             $time, results_o, what, got, want);
  endtask

  always @(posedge clk_i) begin : watch
    fraction_t got, want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = {out_user_i, out_data_i[OUT_TDATA_W-2:0]};
        results_o++;
        if (got.zero_den) zero_den_seen_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("beat with nothing expected, raw numerator", got.raw_num, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.negative !== want.negative)
            report_mismatch("negative", got.negative, want.negative);
          if (got.raw_num !== want.raw_num)
            report_mismatch("raw numerator", got.raw_num, want.raw_num);
          if (got.raw_den !== want.raw_den)
            report_mismatch("raw denominator", got.raw_den, want.raw_den);
          if (got.red_num !== want.red_num)
            report_mismatch("reduced numerator", got.red_num, want.red_num);
          if (got.red_den !== want.red_den)
            report_mismatch("reduced denominator", got.red_den, want.red_den);
          if (got.zero_den !== want.zero_den)
            report_mismatch("zero denominator", got.zero_den, want.zero_den);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_fraction(op_e'(in_user_i), in_data_i[4*VALUE_WIDTH-1:0]));
      pending_o = expected_q.size();
    end
  end

endmodule

/* dv/rational_arith_reduce_top_test.sv */
// Testbench top for the rational arithmetic block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module rational_arith_reduce_top_test;
  import rar_pkg::*;

  localparam int VW          = 16;
  localparam int IN_W        = ((4*VW+7)/8)*8;
  localparam int RANDOM_ITEMS = 1800;
  localparam int RX_HOLD     = 4000;
  localparam int SETTLE      = 2000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata;
  logic [CMD_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  int errors, pending, results, zero_den_seen;
  int items_sent;
  bit tx_steady, rx_steady, rx_hold_req;

  rational_arith_reduce_top #(.VALUE_WIDTH(VW)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rational_arith_reduce_checker #(.VALUE_WIDTH(VW)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_user_i       (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_user_i      (m_axis_tuser),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results),
    .zero_den_seen_o (zero_den_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  // 0 full range, 1 small, 2 small times a random factor, 3 corner values
  function automatic int rand_operand(input int mode);
    case (mode)
      0: return int'($urandom_range(0, 65535));
      1: return int'($urandom_range(0, 40)) - 20;
      2: return (int'($urandom_range(0, 40)) - 20) * int'($urandom_range(1, 800));
      default: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input op_e op, input int ln, input int ld, input int rn,
                           input int rd);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rd[VW-1:0], rn[VW-1:0], ld[VW-1:0], ln[VW-1:0]};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Output side: bursts of ready with random gaps, one long hold-off on request
  initial begin : result_sink
    int burst, gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      burst = $urandom_range(1, 20);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = rx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int i, k, item_mode, m;
    int vals[4];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ADD;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_hold_req   = 1'b0;
    items_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send_item(OP_ADD, 1, 2, 1, 3);
    send_item(OP_SUB, 1, 2, 1, 2);             // zero numerator
    send_item(OP_MUL, -3, 4, 2, -9);           // both parts negative
    send_item(OP_DIV, 5, 7, 0, 3);             // divide by zero fraction
    send_item(OP_ADD, 3, 0, 4, 5);             // zero denominator operand
    send_item(OP_ADD, -32768, -32768, -32768, -32768);
    send_item(OP_MUL, 32767, -32768, -32768, 32767);
    send_item(OP_DIV, -32768, 1, 1, -32768);
    send_item(OP_SUB, 32767, 1, -32768, 1);
    send_item(OP_ADD, 0, 0, 0, 0);
    send_item(OP_MUL, 0, 5, 7, 3);
    send_item(OP_DIV, -1, -1, -1, -1);
    send_item(OP_SUB, 1, 3, 1, 2);
    send_item(OP_ADD, 6, 8, 6, 8);
    send_item(OP_DIV, 4, 9, -2, 3);
    send_item(OP_MUL, 12, 18, 15, 20);
    send_item(OP_ADD, -32768, 32767, 32767, -32768);
    send_item(OP_SUB, -1, 1, 32767, 1);
    send_item(OP_DIV, 0, 0, 0, 0);
    send_item(OP_MUL, -7, 0, -5, 0);
    send_item(OP_SUB, -32768, -1, -32768, -1);
    send_item(OP_DIV, 32767, 32767, 32767, 32767);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (i == 400) rx_hold_req = 1'b1;
      if (i == 1100) drain_results();
      item_mode = $urandom_range(0, 9);
      for (k = 0; k < 4; k++) begin
        m = (item_mode < 4) ? 0 : (item_mode < 6) ? 1 : (item_mode < 8) ? 2 :
            (item_mode == 9) ? 3 : int'($urandom_range(0, 3));
        vals[k] = rand_operand(m);
      end
      send_item(op_e'($urandom_range(0, 3)), vals[0], vals[1], vals[2], vals[3]);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d items over add, subtract, multiply and divide; %0d results compared",
             items_sent, results);
    $display("incl. %0d zero-denominator results, a long output hold-off and a drain pause",
             zero_den_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(60_000_000);
    $display("Timeout with %0d results still expected", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
